// File: rtl/ffa_pkg.sv
// shared constants, mode codes and result bundle for the first-fit allocator
package ffa_pkg;

   localparam int DEF_POOL_WORDS = 1024;
   localparam int MIN_POOL       = 4;
   localparam int MODE_W         = 2;
   localparam int REQ_W          = 10;
   localparam int CSR_W          = 11;
   localparam int CSR_RESET      = 1024;

   typedef enum logic [MODE_W-1:0] {
      MODE_FORMAT = 2'd0,
      MODE_ALLOC  = 2'd1,
      MODE_FREE   = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef struct packed {
      logic             ok;
      logic [REQ_W-1:0] payload_offset;
      logic [REQ_W-1:0] largest_words;
   } res_type;

endpackage

// File: rtl/ffa_if.sv
// request and response channel interfaces of the first-fit allocator
interface ffa_req_if;
   import ffa_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [REQ_W-1:0]  request_words;
   logic [REQ_W-1:0]  block_offset;

   modport source (output valid, output mode, output request_words, output block_offset,
                   input ready);
   modport sink   (input valid, input mode, input request_words, input block_offset,
                   output ready);
endinterface

interface ffa_rsp_if;
   import ffa_pkg::*;

   logic             valid;
   logic             ready;
   logic             ok;
   logic [REQ_W-1:0] payload_offset;
   logic [REQ_W-1:0] largest_words;

   modport source (output valid, output ok, output payload_offset, output largest_words,
                   input ready);
   modport sink   (input valid, input ok, input payload_offset, input largest_words,
                   output ready);
endinterface

// File: rtl/ffa_hdr_ram.sv
// header store: one write port, one read port with registered read data
module ffa_hdr_ram #(
   parameter int DEPTH = ffa_pkg::DEF_POOL_WORDS,
   parameter int AW    = 10,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] hdr_mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         hdr_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= hdr_mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ffa_alu.sv
// shared adder with in-pool compare, used for every walk step
module ffa_alu #(
   parameter int W = 11
) (
   input  logic [W-1:0] a,
   input  logic [W-1:0] b,
   input  logic         cin,
   input  logic [W-1:0] bound,
   output logic [W-1:0] sum,
   output logic         lt
);
   assign sum = a + b + W'(cin);
   assign lt  = (sum < bound);

endmodule

// File: rtl/ffa_ctrl.sv
// sequencer: format, free, merge walk, first-fit walk and largest-block walk
module ffa_ctrl #(
   parameter int POOL_WORDS = ffa_pkg::DEF_POOL_WORDS,
   parameter int AW         = 10,
   parameter int PW         = 11,
   parameter int AUW        = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   ffa_req_if.sink                    req_bus,
   input  logic                       csr_write_enable,
   input  logic [ffa_pkg::CSR_W-1:0]  csr_write_data,
   output logic                       mem_we,
   output logic [AW-1:0]              mem_waddr,
   output logic [AW:0]                mem_wdata,
   output logic                       mem_re,
   output logic [AW-1:0]              mem_raddr,
   input  logic [AW:0]                mem_rdata,
   output logic [AUW-1:0]             alu_a,
   output logic [AUW-1:0]             alu_b,
   output logic                       alu_cin,
   output logic [AUW-1:0]             alu_bound,
   input  logic [AUW-1:0]             alu_sum,
   input  logic                       alu_lt,
   output logic                       res_valid,
   output ffa_pkg::res_type           res,
   input  logic                       res_ready
);
   import ffa_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FR_RD,
      S_FR_WR,
      S_M_RD,
      S_M_EVAL,
      S_M_SCAN,
      S_M_SCANEV,
      S_M_WR,
      S_F_RD,
      S_F_EVAL,
      S_F_SPL_A,
      S_F_SPL_B,
      S_Q_RD,
      S_Q_EVAL,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic             formatted_ff, formatted_in;
   logic [CSR_W-1:0] csr_ff, csr_in;
   logic [PW-1:0]    active_ff, active_in;
   logic [PW-1:0]    h_ff, h_in;
   logic             hlt_ff, hlt_in;
   logic [PW-1:0]    next_ff, next_in;
   logic             nlt_ff, nlt_in;
   logic [AW-1:0]    sz_ff, sz_in;
   logic [AW-1:0]    best_ff, best_in;
   logic [REQ_W-1:0] need_ff, need_in;
   res_type          res_ff, res_in;

   logic             accept;
   logic             rd_used;
   logic [AW-1:0]    rd_size;
   logic [PW-1:0]    clamp_n;
   logic             fits;
   logic             splits;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign rd_used       = mem_rdata[AW];
   assign rd_size       = mem_rdata[AW-1:0];
   assign alu_bound     = AUW'(active_ff);
   assign res_valid     = (state_ff == S_DONE);
   assign res           = res_ff;

   // pool size sampled by format, held inside the supported range
   always_comb begin
      if (AUW'(csr_ff) > AUW'(POOL_WORDS)) begin
         clamp_n = PW'(POOL_WORDS);
      end else if (csr_ff < CSR_W'(MIN_POOL)) begin
         clamp_n = PW'(MIN_POOL);
      end else begin
         clamp_n = PW'(csr_ff);
      end
   end

   assign fits   = !rd_used && (AUW'(rd_size) >= AUW'(need_ff));
   assign splits = (AUW'(rd_size) >= (AUW'(need_ff) + AUW'(2)));

   always_comb begin
      state_in     = state_ff;
      formatted_in = formatted_ff;
      csr_in       = csr_write_enable ? csr_write_data : csr_ff;
      active_in    = active_ff;
      h_in         = h_ff;
      hlt_in       = hlt_ff;
      next_in      = next_ff;
      nlt_in       = nlt_ff;
      sz_in        = sz_ff;
      best_in      = best_ff;
      need_in      = need_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_waddr    = h_ff[AW-1:0];
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = h_ff[AW-1:0];
      // default step: header position plus header word plus block size
      alu_a        = AUW'(h_ff);
      alu_b        = AUW'(rd_size);
      alu_cin      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               need_in = req_bus.request_words;
               h_in    = '0;
               hlt_in  = 1'b1;
               best_in = '0;
               res_in  = '0;
               if (mode_type'(req_bus.mode) == MODE_FORMAT) begin
                  alu_a        = AUW'(clamp_n);
                  alu_b        = '1;
                  alu_cin      = 1'b0;
                  mem_we       = 1'b1;
                  mem_waddr    = '0;
                  mem_wdata    = {1'b0, alu_sum[AW-1:0]};
                  active_in    = clamp_n;
                  formatted_in = 1'b1;
                  res_in.ok    = 1'b1;
                  state_in     = S_DONE;
               end else if (!formatted_ff) begin
                  state_in = S_DONE;
               end else begin
                  unique case (mode_type'(req_bus.mode))
                     MODE_ALLOC: begin
                        state_in = S_M_RD;
                     end
                     MODE_FREE: begin
                        // header sits one word below the payload
                        alu_a     = AUW'(req_bus.block_offset);
                        alu_b     = '1;
                        alu_cin   = 1'b0;
                        res_in.ok = 1'b1;
                        if ((req_bus.block_offset != '0) && alu_lt) begin
                           h_in     = PW'(alu_sum);
                           state_in = S_FR_RD;
                        end else begin
                           state_in = S_DONE;
                        end
                     end
                     default: begin
                        state_in = S_Q_RD;
                     end
                  endcase
               end
            end
         end
         S_FR_RD: begin
            mem_re   = 1'b1;
            state_in = S_FR_WR;
         end
         S_FR_WR: begin
            mem_we    = 1'b1;
            mem_wdata = {1'b0, rd_size};
            state_in  = S_DONE;
         end
         S_M_RD: begin
            if (hlt_ff) begin
               mem_re   = 1'b1;
               state_in = S_M_EVAL;
            end else begin
               h_in     = '0;
               hlt_in   = 1'b1;
               state_in = S_F_RD;
            end
         end
         S_M_EVAL: begin
            if (rd_used) begin
               h_in     = PW'(alu_sum);
               hlt_in   = alu_lt;
               state_in = S_M_RD;
            end else begin
               next_in  = PW'(alu_sum);
               nlt_in   = alu_lt;
               state_in = S_M_SCAN;
            end
         end
         S_M_SCAN: begin
            if (nlt_ff) begin
               mem_re    = 1'b1;
               mem_raddr = next_ff[AW-1:0];
               state_in  = S_M_SCANEV;
            end else begin
               state_in = S_M_WR;
            end
         end
         S_M_SCANEV: begin
            alu_a = AUW'(next_ff);
            if (!rd_used) begin
               next_in  = PW'(alu_sum);
               nlt_in   = alu_lt;
               state_in = S_M_SCAN;
            end else begin
               state_in = S_M_WR;
            end
         end
         S_M_WR: begin
            // merged size is next - h - 1
            alu_a     = AUW'(next_ff);
            alu_b     = ~AUW'(h_ff);
            alu_cin   = 1'b0;
            mem_we    = 1'b1;
            mem_wdata = {1'b0, alu_sum[AW-1:0]};
            h_in      = next_ff;
            hlt_in    = nlt_ff;
            state_in  = S_M_RD;
         end
         S_F_RD: begin
            if (hlt_ff) begin
               mem_re   = 1'b1;
               state_in = S_F_EVAL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_F_EVAL: begin
            if (fits) begin
               alu_b   = '0;
               next_in = PW'(alu_sum);
               sz_in   = rd_size;
               if (splits) begin
                  state_in = S_F_SPL_A;
               end else begin
                  mem_we                = 1'b1;
                  mem_wdata             = {1'b1, rd_size};
                  res_in.ok             = 1'b1;
                  res_in.payload_offset = REQ_W'(alu_sum);
                  state_in              = S_DONE;
               end
            end else begin
               h_in     = PW'(alu_sum);
               hlt_in   = alu_lt;
               state_in = S_F_RD;
            end
         end
         S_F_SPL_A: begin
            // used header now, then locate the remainder header
            alu_a     = AUW'(next_ff);
            alu_b     = AUW'(need_ff);
            alu_cin   = 1'b0;
            mem_we    = 1'b1;
            mem_wdata = {1'b1, AW'(need_ff)};
            h_in      = PW'(alu_sum);
            state_in  = S_F_SPL_B;
         end
         S_F_SPL_B: begin
            // remainder size is size - need - 1
            alu_a                 = AUW'(sz_ff);
            alu_b                 = ~AUW'(need_ff);
            alu_cin               = 1'b0;
            mem_we                = 1'b1;
            mem_wdata             = {1'b0, alu_sum[AW-1:0]};
            res_in.ok             = 1'b1;
            res_in.payload_offset = REQ_W'(next_ff);
            state_in              = S_DONE;
         end
         S_Q_RD: begin
            if (hlt_ff) begin
               mem_re   = 1'b1;
               state_in = S_Q_EVAL;
            end else begin
               res_in.ok            = 1'b1;
               res_in.largest_words = REQ_W'(best_ff);
               state_in             = S_DONE;
            end
         end
         S_Q_EVAL: begin
            if (!rd_used && (rd_size > best_ff)) begin
               best_in = rd_size;
            end
            h_in     = PW'(alu_sum);
            hlt_in   = alu_lt;
            state_in = S_Q_RD;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         formatted_ff <= 1'b0;
         csr_ff       <= CSR_W'(CSR_RESET);
         active_ff    <= PW'(POOL_WORDS);
      end else begin
         state_ff     <= state_in;
         formatted_ff <= formatted_in;
         csr_ff       <= csr_in;
         active_ff    <= active_in;
      end
      h_ff    <= h_in;
      hlt_ff  <= hlt_in;
      next_ff <= next_in;
      nlt_ff  <= nlt_in;
      sz_ff   <= sz_in;
      best_ff <= best_in;
      need_ff <= need_in;
      res_ff  <= res_in;
   end

endmodule

// File: rtl/first_fit_block_allocator.sv
// top level of the first-fit variable-size pool allocator
// format writes the first header, null or out-of-pool free and unformatted items touch none,
//    and a free reads its header and writes it back as free
// allocate: merge walk folds each run of free blocks into its first header, then the first-fit
//    walk takes the first free block that fits, splitting it when a header and a word remain
// query: walks for the largest free block; one item at a time, bound by the single header read port
// reset: synchronous, clears control and the format flag; the header store is not cleared
module first_fit_block_allocator #(
   parameter int POOL_WORDS = ffa_pkg::DEF_POOL_WORDS
) (
   input  logic                      clock,
   input  logic                      reset,
   ffa_req_if.sink                   req_bus,
   ffa_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_enable,
   input  logic [ffa_pkg::CSR_W-1:0] csr_write_data
);
   import ffa_pkg::*;

   // header word: used mark on top, payload size below
   localparam int AW  = $clog2(POOL_WORDS);
   localparam int PW  = $clog2(POOL_WORDS + 1);
   localparam int DW  = AW + 1;
   // adder wide enough for positions, the pool register and request + 2
   localparam int AUW = (PW > CSR_W) ? PW : CSR_W;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [DW-1:0]  mem_wdata;
   logic           mem_re;
   logic [AW-1:0]  mem_raddr;
   logic [DW-1:0]  mem_rdata;
   logic [AUW-1:0] alu_a;
   logic [AUW-1:0] alu_b;
   logic           alu_cin;
   logic [AUW-1:0] alu_bound;
   logic [AUW-1:0] alu_sum;
   logic           alu_lt;

   logic           res_valid;
   res_type        res;
   logic           res_ready;

   // output beat register, so a finished result can wait for the sink
   logic           rsp_valid_ff, rsp_valid_in;
   res_type        rsp_data_ff, rsp_data_in;

   ffa_hdr_ram #(
      .DEPTH (POOL_WORDS),
      .AW    (AW),
      .DW    (DW)
   ) u_hdr_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   ffa_alu #(
      .W (AUW)
   ) u_alu (
      .a     (alu_a),
      .b     (alu_b),
      .cin   (alu_cin),
      .bound (alu_bound),
      .sum   (alu_sum),
      .lt    (alu_lt)
   );

   ffa_ctrl #(
      .POOL_WORDS (POOL_WORDS),
      .AW         (AW),
      .PW         (PW),
      .AUW        (AUW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mem_we           (mem_we),
      .mem_waddr        (mem_waddr),
      .mem_wdata        (mem_wdata),
      .mem_re           (mem_re),
      .mem_raddr        (mem_raddr),
      .mem_rdata        (mem_rdata),
      .alu_a            (alu_a),
      .alu_b            (alu_b),
      .alu_cin          (alu_cin),
      .alu_bound        (alu_bound),
      .alu_sum          (alu_sum),
      .alu_lt           (alu_lt),
      .res_valid        (res_valid),
      .res              (res),
      .res_ready        (res_ready)
   );

   // slot is free when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.ok             = rsp_data_ff.ok;
   assign rsp_bus.payload_offset = rsp_data_ff.payload_offset;
   assign rsp_bus.largest_words  = rsp_data_ff.largest_words;

endmodule

// File: rtl/ffa_checker.sv
// port-level checks for the first-fit allocator, bound to the top level
module ffa_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_ok,
   input logic [ffa_pkg::REQ_W-1:0] rsp_payload_offset,
   input logic [ffa_pkg::REQ_W-1:0] rsp_largest_words
);
   import ffa_pkg::*;

   // a stalled beat keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
         $stable(rsp_payload_offset) && $stable(rsp_largest_words))
      else $error("response beat changed while stalled");

   // one item at a time: no new request straight after an accepted one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous item still in work");

   // a failed or unformatted item carries no offset and no size
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> (rsp_payload_offset == '0) && (rsp_largest_words == '0))
      else $error("failed response carries data");

   // an allocated offset only comes with success and no size report
   a_offset_alloc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload_offset != '0) |-> rsp_ok && (rsp_largest_words == '0))
      else $error("offset reported outside a successful allocation");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_ok             (rsp_bus.ok),
   .rsp_payload_offset (rsp_bus.payload_offset),
   .rsp_largest_words  (rsp_bus.largest_words)
);
